/* hdl/energy_vad_endpoint_detector_assert.svh */
`ifndef ENERGY_VAD_ENDPOINT_DETECTOR_ASSERT_SVH
`define ENERGY_VAD_ENDPOINT_DETECTOR_ASSERT_SVH

// Concurrent checks on clk_i, disabled while rst_ni is low.

// Condition that must hold at every edge.
`define EVAD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define EVAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hdl/evad_pkg.sv */
`timescale 1ns / 1ps

package evad_pkg;

  localparam int unsigned MAX_FRAME_SAMPLES_DEF = 1024;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned SQ_W        = 2 * SAMPLE_W - 1;
  localparam int unsigned RMS_W       = 16;
  localparam int unsigned NF_FRAC     = 8;
  localparam int unsigned NF_W        = RMS_W + NF_FRAC;
  localparam int unsigned THR_W       = 16;
  localparam int unsigned TICK_W      = 17;
  localparam int unsigned ALPHA_W     = 11;
  localparam int unsigned ALPHA_FRAC  = 10;
  localparam int unsigned ALPHA_RND   = (1 << ALPHA_FRAC) - 1;
  localparam int unsigned MARGIN_W    = 8;
  localparam int unsigned MARGIN_FRAC = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_AW    = 1;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

  localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FRAC);

  localparam logic [THR_W-1:0]    MIN_THR_RST = 16'd700;
  localparam logic [THR_W-1:0]    SILENCE_RST = 16'd800;
  localparam logic [THR_W-1:0]    LISTEN_RST  = 16'd8000;
  localparam logic [ALPHA_W-1:0]  ALPHA_RST   = 11'd20;
  localparam logic [MARGIN_W-1:0] MARGIN_RST  = 8'd32;
  localparam logic [NF_W-1:0]     NF_RST      = NF_W'(MIN_THR_RST) << NF_FRAC;

  typedef enum logic [1:0] {
    ACT_SAMPLE,
    ACT_TICK,
    ACT_START,
    ACT_END
  } action_e;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_SILENCE,
    EV_TIMEOUT,
    EV_NO_SPEECH
  } event_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_CAPTURE,
    MODE_WAIT
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_THR,
    CFG_SILENCE,
    CFG_LISTEN,
    CFG_ALPHA,
    CFG_MARGIN
  } cfg_idx_e;

  typedef struct packed {
    logic [THR_W-1:0]    min_threshold;
    logic [THR_W-1:0]    silence_limit_ms;
    logic [THR_W-1:0]    listen_limit_ms;
    logic [ALPHA_W-1:0]  alpha_q10;
    logic [MARGIN_W-1:0] margin_q4;
  } cfg_t;

  // One classified word as it waits in the queue.
  typedef struct packed {
    action_e         act;
    logic            last;
    logic [SQ_W-1:0] sq;
  } q_item_t;

endpackage

/* hdl/evad_if.sv */
`timescale 1ns / 1ps

interface evad_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic signed [31:0] mic_word;
  logic        frame_last;

  modport source (output valid, action, mic_word, frame_last, input ready);
  modport sink (input valid, action, mic_word, frame_last, output ready);
endinterface

interface evad_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [1:0]  mode_now;
  logic        speech_flag;
  logic [15:0] frozen_threshold;
  logic [15:0] floor_level;

  modport source (output valid, event_res, mode_now, speech_flag, frozen_threshold,
                  floor_level, input ready);
  modport sink (input valid, event_res, mode_now, speech_flag, frozen_threshold,
                floor_level, output ready);
endinterface

/* hdl/evad_fifo.sv */
`timescale 1ns / 1ps
`include "energy_vad_endpoint_detector_assert.svh"

module evad_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  evad_pkg::q_item_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output evad_pkg::q_item_t item_o,
  output logic              empty_o
);

  evad_pkg::q_item_t mem_q [evad_pkg::QUEUE_DEPTH];

  logic [evad_pkg::QUEUE_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [evad_pkg::QUEUE_AW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (evad_pkg::QUEUE_AW + 1)'(evad_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (evad_pkg::QUEUE_AW + 1)'(push_i) - (evad_pkg::QUEUE_AW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  `EVAD_ASSERT_ALWAYS(a_q_cnt_bound, cnt_q <= (evad_pkg::QUEUE_AW + 1)'(evad_pkg::QUEUE_DEPTH), "queue count past depth")
  `EVAD_ASSERT_NOW(a_q_push_full, push_i, !full_o, "push into full queue")
  `EVAD_ASSERT_NOW(a_q_pop_empty, pop_i, !empty_o, "pop from empty queue")

endmodule

/* hdl/evad_front.sv */
`timescale 1ns / 1ps

module evad_front (
  evad_in_if.sink           in_i,
  input  logic              full_i,
  output logic              push_o,
  output evad_pkg::q_item_t item_o
);

  logic [evad_pkg::SAMPLE_W-1:0] top;
  logic [evad_pkg::SAMPLE_W-1:0] mag;
  logic [2*evad_pkg::SAMPLE_W-1:0] sq_full;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // Keep the upper half of the word; magnitude of the most negative value fits unsigned.
  always_comb begin
    top     = in_i.mic_word[evad_pkg::WORD_W-1 -: evad_pkg::SAMPLE_W];
    mag     = top[evad_pkg::SAMPLE_W-1] ? (~top + 1'b1) : top;
    sq_full = (2 * evad_pkg::SAMPLE_W)'(mag) * (2 * evad_pkg::SAMPLE_W)'(mag);
    item_o.act  = evad_pkg::action_e'(in_i.action);
    item_o.last = in_i.frame_last;
    item_o.sq   = sq_full[evad_pkg::SQ_W-1:0];
  end

endmodule

/* hdl/evad_rms.sv */
`timescale 1ns / 1ps

module evad_rms #(
  parameter int unsigned MAX_FRAME_SAMPLES = evad_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [evad_pkg::SQ_W+$clog2(MAX_FRAME_SAMPLES+1)-1:0] sum_i,
  input  logic [$clog2(MAX_FRAME_SAMPLES+1)-1:0] cnt_i,
  output logic                          done_o,
  output logic [evad_pkg::RMS_W-1:0]    rms_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int unsigned SUM_W  = evad_pkg::SQ_W + CNT_W;
  localparam int unsigned STEP_W = $clog2(SUM_W);
  localparam int unsigned SQRT_W = 2 * evad_pkg::RMS_W;
  localparam int unsigned REM_W  = evad_pkg::RMS_W + 2;

  typedef enum logic [1:0] {
    R_IDLE,
    R_DIV,
    R_SQRT
  } state_e;

  state_e              state_q;
  logic [STEP_W-1:0]   step_q;
  logic                done_q;

  logic [SUM_W-1:0]    dq_q;
  logic [CNT_W-1:0]    div_q;
  logic [CNT_W-1:0]    rem_q;
  logic [SQRT_W-1:0]   x_q;
  logic [evad_pkg::RMS_W-1:0] root_q;
  logic [REM_W-1:0]    srem_q;

  logic [CNT_W:0]      rem_sh, rem_sub;
  logic                div_ge;
  logic [REM_W+1:0]    srem_sh, trial, srem_sub;
  logic                sq_ge;

  // One quotient bit per cycle, then one root bit per cycle.
  always_comb begin
    rem_sh   = {rem_q, dq_q[SUM_W-1]};
    div_ge   = (rem_sh >= {1'b0, div_q});
    rem_sub  = rem_sh - {1'b0, div_q};
    srem_sh  = {srem_q, x_q[SQRT_W-1 -: 2]};
    trial    = {2'b00, root_q, 2'b01};
    sq_ge    = (srem_sh >= trial);
    srem_sub = srem_sh - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        R_IDLE: begin
          if (start_i) begin
            state_q <= R_DIV;
            step_q  <= STEP_W'(SUM_W - 1);
          end
        end
        R_DIV: begin
          step_q <= step_q - 1'b1;
          if (step_q == '0) begin
            state_q <= R_SQRT;
            step_q  <= STEP_W'(evad_pkg::RMS_W - 1);
          end
        end
        R_SQRT: begin
          step_q <= step_q - 1'b1;
          if (step_q == '0) begin
            state_q <= R_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= R_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      R_IDLE: begin
        if (start_i) begin
          dq_q  <= sum_i;
          div_q <= cnt_i;
          rem_q <= '0;
        end
      end
      R_DIV: begin
        rem_q <= div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        dq_q  <= {dq_q[SUM_W-2:0], div_ge};
        if (step_q == '0) begin
          // The mean never exceeds the largest square, so the low bits carry it all.
          x_q    <= {dq_q[SQRT_W-2:0], div_ge};
          root_q <= '0;
          srem_q <= '0;
        end
      end
      R_SQRT: begin
        srem_q <= sq_ge ? srem_sub[REM_W-1:0] : srem_sh[REM_W-1:0];
        root_q <= {root_q[evad_pkg::RMS_W-2:0], sq_ge};
        x_q    <= {x_q[SQRT_W-3:0], 2'b00};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign rms_o  = root_q;

endmodule

/* hdl/evad_back.sv */
`timescale 1ns / 1ps
`include "energy_vad_endpoint_detector_assert.svh"

module evad_back #(
  parameter int unsigned MAX_FRAME_SAMPLES = evad_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  evad_pkg::cfg_t    cfg_i,
  input  logic              q_empty_i,
  input  evad_pkg::q_item_t q_item_i,
  output logic              q_pop_o,
  evad_out_if.source        res_o
);

  localparam int unsigned CNT_W   = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int unsigned SUM_W   = evad_pkg::SQ_W + CNT_W;
  localparam int unsigned THR2_W  = 2 * evad_pkg::THR_W;
  localparam int unsigned LIM_W   = THR2_W + CNT_W;
  localparam int unsigned PROD_W  = evad_pkg::NF_W + evad_pkg::ALPHA_W;
  localparam int unsigned MARG_PW = evad_pkg::NF_W + evad_pkg::MARGIN_W;
  localparam int unsigned THR_SH  = evad_pkg::NF_FRAC + evad_pkg::MARGIN_FRAC;
  localparam int unsigned P_W     = MARG_PW - THR_SH;

  typedef enum logic [3:0] {
    B_FETCH,
    B_RMS_GO,
    B_RMS_WAIT,
    B_EWMA_DIFF,
    B_EWMA_MUL,
    B_NF_UPD,
    B_LIM_SQ,
    B_LIM_MUL,
    B_LIM_CMP,
    B_START_MUL,
    B_START_SET,
    B_EMIT
  } state_e;

  state_e                         state_q;
  evad_pkg::mode_e                mode_q;
  evad_pkg::event_e               ev_q;
  logic [evad_pkg::NF_W-1:0]      nf_q;
  logic [evad_pkg::THR_W-1:0]     thr_q;
  logic [SUM_W-1:0]               sum_q;
  logic [CNT_W-1:0]               cnt_q;
  logic                           speech_q;
  logic [evad_pkg::TICK_W-1:0]    quiet_q;
  logic [evad_pkg::TICK_W-1:0]    elapsed_q;

  logic                           res_valid_q;
  evad_pkg::event_e               res_ev_q;
  evad_pkg::mode_e                res_mode_q;
  logic                           res_speech_q;
  logic [evad_pkg::THR_W-1:0]     res_thr_q;
  logic [evad_pkg::RMS_W-1:0]     res_floor_q;

  // Free-running arithmetic stages; the sequencer waits for them.
  logic                           up_q;
  logic [evad_pkg::NF_W-1:0]      diff_q;
  logic [PROD_W-1:0]              prod_q;
  logic [THR2_W-1:0]              thr2_q;
  logic [LIM_W-1:0]               lim_q;
  logic [MARG_PW-1:0]             nfm_q;

  logic                           rms_done;
  logic [evad_pkg::RMS_W-1:0]     rms;

  logic [CNT_W-1:0]               cnt_inc;
  logic [SUM_W-1:0]               sum_inc;
  logic                           frame_end;
  logic [evad_pkg::TICK_W-1:0]    quiet_inc, elapsed_inc;
  logic                           silence_over, listen_over;
  logic [evad_pkg::ALPHA_W-1:0]   alpha_eff;
  logic [evad_pkg::NF_W-1:0]      target;
  logic [PROD_W:0]                prod_rnd;
  logic [evad_pkg::NF_W-1:0]      nf_up, nf_dn;
  logic [P_W-1:0]                 thr_p;
  logic [evad_pkg::THR_W-1:0]     thr_sat, thr_new;
  logic                           res_free;

  evad_rms #(
    .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
  ) u_rms (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == B_RMS_GO),
    .sum_i  (sum_q),
    .cnt_i  (cnt_q),
    .done_o (rms_done),
    .rms_o  (rms)
  );

  always_comb begin
    cnt_inc      = cnt_q + 1'b1;
    sum_inc      = sum_q + SUM_W'(q_item_i.sq);
    frame_end    = q_item_i.last || (cnt_inc >= CNT_W'(MAX_FRAME_SAMPLES));
    quiet_inc    = (quiet_q == evad_pkg::TICK_MAX) ? quiet_q : quiet_q + 1'b1;
    elapsed_inc  = (elapsed_q == evad_pkg::TICK_MAX) ? elapsed_q : elapsed_q + 1'b1;
    silence_over = (quiet_inc > evad_pkg::TICK_W'(cfg_i.silence_limit_ms));
    listen_over  = (elapsed_inc > evad_pkg::TICK_W'(cfg_i.listen_limit_ms));
    alpha_eff    = (cfg_i.alpha_q10 > evad_pkg::ALPHA_ONE) ? evad_pkg::ALPHA_ONE
                                                           : cfg_i.alpha_q10;
    target       = evad_pkg::NF_W'(rms) << evad_pkg::NF_FRAC;
    // Round the downward step up so the floor never drops below its target.
    prod_rnd     = {1'b0, prod_q} + (PROD_W + 1)'(evad_pkg::ALPHA_RND);
    nf_up        = nf_q + prod_q[evad_pkg::ALPHA_FRAC +: evad_pkg::NF_W];
    nf_dn        = nf_q - prod_rnd[evad_pkg::ALPHA_FRAC +: evad_pkg::NF_W];
    thr_p        = nfm_q[MARG_PW-1:THR_SH];
    thr_sat      = (|thr_p[P_W-1:evad_pkg::THR_W]) ? '1 : thr_p[evad_pkg::THR_W-1:0];
    thr_new      = (thr_sat > cfg_i.min_threshold) ? thr_sat : cfg_i.min_threshold;
    res_free     = !res_valid_q || res_o.ready;
  end

  assign q_pop_o = (state_q == B_FETCH) && !q_empty_i;

  always_ff @(posedge clk_i) begin
    up_q   <= (target >= nf_q);
    diff_q <= (target >= nf_q) ? target - nf_q : nf_q - target;
    prod_q <= PROD_W'(diff_q) * PROD_W'(alpha_eff);
    thr2_q <= THR2_W'(thr_q) * THR2_W'(thr_q);
    lim_q  <= LIM_W'(thr2_q) * LIM_W'(cnt_q);
    nfm_q  <= MARG_PW'(nf_q) * MARG_PW'(cfg_i.margin_q4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_FETCH;
      mode_q       <= evad_pkg::MODE_IDLE;
      ev_q         <= evad_pkg::EV_NONE;
      nf_q         <= evad_pkg::NF_RST;
      thr_q        <= evad_pkg::MIN_THR_RST;
      sum_q        <= '0;
      cnt_q        <= '0;
      speech_q     <= 1'b0;
      quiet_q      <= '0;
      elapsed_q    <= '0;
      res_valid_q  <= 1'b0;
      res_ev_q     <= evad_pkg::EV_NONE;
      res_mode_q   <= evad_pkg::MODE_IDLE;
      res_speech_q <= 1'b0;
      res_thr_q    <= '0;
      res_floor_q  <= '0;
    end else begin
      // Load a new result word or drop the one the receiver took.
      if (state_q == B_EMIT && res_free) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_FETCH: begin
          if (!q_empty_i) begin
            ev_q    <= evad_pkg::EV_NONE;
            state_q <= B_EMIT;
            unique case (q_item_i.act)
              evad_pkg::ACT_SAMPLE: begin
                // Drop samples while waiting for session end.
                if (mode_q != evad_pkg::MODE_WAIT) begin
                  sum_q <= sum_inc;
                  cnt_q <= cnt_inc;
                  if (frame_end) begin
                    state_q <= (mode_q == evad_pkg::MODE_IDLE) ? B_RMS_GO : B_LIM_SQ;
                  end
                end
              end
              evad_pkg::ACT_TICK: begin
                if (mode_q == evad_pkg::MODE_CAPTURE) begin
                  quiet_q   <= quiet_inc;
                  elapsed_q <= elapsed_inc;
                  priority if (speech_q && silence_over) begin
                    ev_q   <= evad_pkg::EV_SILENCE;
                    mode_q <= evad_pkg::MODE_WAIT;
                  end else if (!speech_q && listen_over) begin
                    ev_q   <= evad_pkg::EV_NO_SPEECH;
                    mode_q <= evad_pkg::MODE_IDLE;
                    sum_q  <= '0;
                    cnt_q  <= '0;
                  end else if (listen_over) begin
                    ev_q   <= evad_pkg::EV_TIMEOUT;
                    mode_q <= evad_pkg::MODE_WAIT;
                  end else begin
                    ev_q   <= evad_pkg::EV_NONE;
                  end
                end
              end
              evad_pkg::ACT_START: begin
                if (mode_q == evad_pkg::MODE_IDLE) begin
                  speech_q  <= 1'b0;
                  quiet_q   <= '0;
                  elapsed_q <= '0;
                  sum_q     <= '0;
                  cnt_q     <= '0;
                  mode_q    <= evad_pkg::MODE_CAPTURE;
                  state_q   <= B_START_MUL;
                end
              end
              evad_pkg::ACT_END: begin
                mode_q <= evad_pkg::MODE_IDLE;
                sum_q  <= '0;
                cnt_q  <= '0;
              end
            endcase
          end
        end
        B_RMS_GO: begin
          // The root unit has latched the frame; clear the accumulator.
          sum_q   <= '0;
          cnt_q   <= '0;
          state_q <= B_RMS_WAIT;
        end
        B_RMS_WAIT: begin
          if (rms_done) begin
            state_q <= B_EWMA_DIFF;
          end
        end
        B_EWMA_DIFF: state_q <= B_EWMA_MUL;
        B_EWMA_MUL:  state_q <= B_NF_UPD;
        B_NF_UPD: begin
          nf_q    <= up_q ? nf_up : nf_dn;
          state_q <= B_EMIT;
        end
        B_LIM_SQ:  state_q <= B_LIM_MUL;
        B_LIM_MUL: state_q <= B_LIM_CMP;
        B_LIM_CMP: begin
          if (LIM_W'(sum_q) >= lim_q) begin
            speech_q <= 1'b1;
            quiet_q  <= '0;
          end
          sum_q   <= '0;
          cnt_q   <= '0;
          state_q <= B_EMIT;
        end
        B_START_MUL: state_q <= B_START_SET;
        B_START_SET: begin
          thr_q   <= thr_new;
          state_q <= B_EMIT;
        end
        B_EMIT: begin
          if (res_free) begin
            res_ev_q     <= ev_q;
            res_mode_q   <= mode_q;
            res_speech_q <= speech_q;
            res_thr_q    <= thr_q;
            res_floor_q  <= nf_q[evad_pkg::NF_W-1:evad_pkg::NF_FRAC];
            state_q      <= B_FETCH;
          end
        end
        default: state_q <= B_FETCH;
      endcase
    end
  end

  assign res_o.valid            = res_valid_q;
  assign res_o.event_res        = res_ev_q;
  assign res_o.mode_now         = res_mode_q;
  assign res_o.speech_flag      = res_speech_q;
  assign res_o.frozen_threshold = res_thr_q;
  assign res_o.floor_level      = res_floor_q;

  `EVAD_ASSERT_NOW(a_rms_done_wait, rms_done, state_q == B_RMS_WAIT, "root result outside wait state")
  `EVAD_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(MAX_FRAME_SAMPLES), "frame count past limit")
  `EVAD_ASSERT_NOW(a_start_clear, mode_q == evad_pkg::MODE_CAPTURE && $past(mode_q) == evad_pkg::MODE_IDLE, !speech_q && elapsed_q == '0, "capture entered without clearing")

endmodule

/* hdl/energy_vad_endpoint_detector.sv */
`timescale 1ns / 1ps
// Energy voice-activity endpoint detector with an adaptive noise floor.
// in_i carries one word per handshake: a microphone sample (with frame_last),
// a millisecond tick, a start-capture or a session-end action. res_o returns
// exactly one word per input word, in order: event, mode, speech flag, frozen
// threshold and integer noise floor after that input.
// cfg_* writes a register; write only while the block is idle.
// After the back end fetches an input word, ticks, session ends, dropped words
// and mid-frame samples go straight to the result register; a start first
// takes floor times margin and saturates it; a frame end while capturing
// squares the threshold, scales it by the count and compares; a frame end
// while idle runs the serial divider and root, one bit per cycle, then
// updates the floor. The back end takes the next word from the queue only
// after the result of the last one is loaded, in its fetch / emit sequence.
// A two-entry queue separates the input side from the sequencer, and the
// result sits in an output register, so input words keep being taken while
// the receiver stalls until the queue fills; then in_i.ready drops.
// Reset (rst_ni low, asynchronous) sets idle mode, clears the accumulator and
// counters, loads the default registers, threshold 700 and floor 700.0.
module energy_vad_endpoint_detector #(
  parameter int unsigned MAX_FRAME_SAMPLES = evad_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [evad_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [evad_pkg::CFG_DATA_W-1:0] cfg_data_i,
  evad_in_if.sink                         in_i,
  evad_out_if.source                      res_o
);

  evad_pkg::cfg_t    cfg_q, cfg_d;
  logic              push, full, pop, empty;
  evad_pkg::q_item_t push_item, pop_item;

  // Register writes; indexes beyond the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        evad_pkg::CFG_MIN_THR: cfg_d.min_threshold    = cfg_data_i[evad_pkg::THR_W-1:0];
        evad_pkg::CFG_SILENCE: cfg_d.silence_limit_ms = cfg_data_i[evad_pkg::THR_W-1:0];
        evad_pkg::CFG_LISTEN:  cfg_d.listen_limit_ms  = cfg_data_i[evad_pkg::THR_W-1:0];
        evad_pkg::CFG_ALPHA:   cfg_d.alpha_q10        = cfg_data_i[evad_pkg::ALPHA_W-1:0];
        evad_pkg::CFG_MARGIN:  cfg_d.margin_q4        = cfg_data_i[evad_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_threshold    <= evad_pkg::MIN_THR_RST;
      cfg_q.silence_limit_ms <= evad_pkg::SILENCE_RST;
      cfg_q.listen_limit_ms  <= evad_pkg::LISTEN_RST;
      cfg_q.alpha_q10        <= evad_pkg::ALPHA_RST;
      cfg_q.margin_q4        <= evad_pkg::MARGIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: take the word, keep the top half, square it, classify the action.
  evad_front u_front (
    .in_i  (in_i),
    .full_i(full),
    .push_o(push),
    .item_o(push_item)
  );

  evad_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (full),
    .pop_i  (pop),
    .item_o (pop_item),
    .empty_o(empty)
  );

  // Back: accumulate, run frame-end math and timers, hold the result word.
  evad_back #(
    .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_empty_i(empty),
    .q_item_i (pop_item),
    .q_pop_o  (pop),
    .res_o    (res_o)
  );

endmodule
